[hdl/xgcd_pkg.sv]
`timescale 1ns / 1ps

package xgcd_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int COEF_WIDTH    = OPERAND_WIDTH + 1;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0]       opnd_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic [CNT_WIDTH-1:0]           cnt_t;

    localparam cnt_t CNT_LAST = cnt_t'(OPERAND_WIDTH - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

[hdl/xgcd_req_if.sv]
`timescale 1ns / 1ps

interface xgcd_req_if;

    logic              valid;
    logic              ready;
    xgcd_pkg::opnd_t   first_operand;
    xgcd_pkg::opnd_t   second_operand;

    modport source (
        output valid,
        output first_operand,
        output second_operand,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_operand,
        input  second_operand,
        output ready
    );

endinterface

[hdl/xgcd_rsp_if.sv]
`timescale 1ns / 1ps

interface xgcd_rsp_if;

    logic              valid;
    logic              ready;
    xgcd_pkg::coef_t   coef_first;
    xgcd_pkg::coef_t   coef_second;
    xgcd_pkg::opnd_t   divisor_common;

    modport source (
        output valid,
        output coef_first,
        output coef_second,
        output divisor_common,
        input  ready
    );

    modport sink (
        input  valid,
        input  coef_first,
        input  coef_second,
        input  divisor_common,
        output ready
    );

endinterface

[hdl/extended_gcd_top.sv]
// Extended Euclidean algorithm: for operands a and b it returns the gcd and
// Bezout coefficients s and t with a*s + b*t equal to the gcd.
// The request channel carries first_operand (a) and second_operand (b); the
// response channel carries coef_first (s), coef_second (t), both two's
// complement, and divisor_common (the gcd).
// One item is processed at a time. The request side is ready only while the
// block is idle. Each Euclid step runs a restoring divider, one quotient bit
// per cycle, which also accumulates the quotient times the current
// coefficients by shift and add; the update state then rotates the remainders
// and coefficients and the check state tests for a zero remainder. A 32-bit
// operand pair takes up to about 47 Euclid steps.
// The request side is ready again in the cycle after the response transfer.
// The result is held on the response channel until its transfer completes;
// a stalled receiver simply keeps the block busy.
// Reset returns the sequencer to idle and drops response valid; any item in
// progress is lost.
`timescale 1ns / 1ps

module extended_gcd_top (
    input  logic             clk,
    input  logic             rst_n,
    xgcd_req_if.sink         req,
    xgcd_rsp_if.source       rsp
);

    import xgcd_pkg::*;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;

    opnd_t  ra_reg, ra_next;
    opnd_t  rb_reg, rb_next;
    coef_t  sa_reg, sa_next;
    coef_t  ta_reg, ta_next;
    coef_t  sb_reg, sb_next;
    coef_t  tb_reg, tb_next;
    opnd_t  rem_reg, rem_next;
    opnd_t  dvd_reg, dvd_next;
    coef_t  acc_s_reg, acc_s_next;
    coef_t  acc_t_reg, acc_t_next;

    logic [OPERAND_WIDTH:0] trial;
    opnd_t                  diff;
    logic                   qbit;

    assign trial = {rem_reg, dvd_reg[OPERAND_WIDTH-1]};
    assign diff  = trial[OPERAND_WIDTH-1:0] - ra_reg;
    assign qbit  = (trial >= {1'b0, ra_reg});

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = (state_reg == ST_DONE);
    assign rsp.coef_first     = sb_reg;
    assign rsp.coef_second    = tb_reg;
    assign rsp.divisor_common = rb_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        sa_next    = sa_reg;
        ta_next    = ta_reg;
        sb_next    = sb_reg;
        tb_next    = tb_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        acc_s_next = acc_s_reg;
        acc_t_next = acc_t_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    ra_next    = req.first_operand;
                    rb_next    = req.second_operand;
                    sa_next    = coef_t'(1);
                    ta_next    = '0;
                    sb_next    = '0;
                    tb_next    = coef_t'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (ra_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = rb_reg;
                    acc_s_next = '0;
                    acc_t_next = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next   = qbit ? diff : trial[OPERAND_WIDTH-1:0];
                dvd_next   = {dvd_reg[OPERAND_WIDTH-2:0], 1'b0};
                acc_s_next = {acc_s_reg[COEF_WIDTH-2:0], 1'b0} + (qbit ? sa_reg : coef_t'(0));
                acc_t_next = {acc_t_reg[COEF_WIDTH-2:0], 1'b0} + (qbit ? ta_reg : coef_t'(0));
                cnt_next   = cnt_reg + cnt_t'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                rb_next    = ra_reg;
                sb_next    = sa_reg;
                tb_next    = ta_reg;
                ra_next    = rem_reg;
                sa_next    = sb_reg - acc_s_reg;
                ta_next    = tb_reg - acc_t_reg;
                state_next = ST_CHECK;
            end
            ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        sa_reg    <= sa_next;
        ta_reg    <= ta_next;
        sb_reg    <= sb_next;
        tb_reg    <= tb_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        acc_s_reg <= acc_s_next;
        acc_t_reg <= acc_t_next;
    end

    // The partial remainder always stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < ra_reg))
        else $error("partial remainder not below divisor");

    // A division goes on to the update after its last quotient bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_LAST) |=> (state_reg == ST_UPDATE))
        else $error("division did not end after its last quotient bit");

    // A request transfer starts the zero test of the first remainder.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_CHECK))
        else $error("request transfer did not start the sequencer");

    // A result is only offered while no new request can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !req.ready)
        else $error("response valid while request side ready");

    // An update is always preceded by a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |-> (ra_reg != '0))
        else $error("update with zero divisor");

endmodule
